// ----- design/slms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, field widths and codes for the sparse local mean subtract unit.
// No dependencies; every other file of the block depends on this package.
package slms_pkg;

  // Transaction field widths.
  localparam int POS_X_W    = 6;
  localparam int POS_Y_W    = 6;
  localparam int POS_Z_W    = 5;
  localparam int VOXEL_W    = 16;
  localparam int RESULT_W   = 16;

  // Configuration port and register widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int DIM_XY_W   = 7;
  localparam int DIM_Z_W    = 6;
  localparam int STEP_W     = 5;

  // Neighbour coordinates can reach one below the largest dimension value.
  localparam int NB_XY_W    = 7;
  localparam int NB_Z_W     = 6;
  // Three times the largest step.
  localparam int DIST_W     = 7;
  // Neighbour count and its upper bound.
  localparam int CNT_W         = 5;
  localparam int MAX_NEIGHBORS = 18;

  // Default sizes of the storage.
  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int DEF_MAX_DEPTH   = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // Register reset values.
  localparam logic [DIM_XY_W-1:0] RST_VOL_WIDTH  = 7'd64;
  localparam logic [DIM_XY_W-1:0] RST_VOL_HEIGHT = 7'd64;
  localparam logic [DIM_Z_W-1:0]  RST_VOL_DEPTH  = 6'd32;
  localparam logic [STEP_W-1:0]   RST_RING_STEP  = 5'd5;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_VOL_WIDTH  = 4'd0;
  localparam cfg_idx_t REG_VOL_HEIGHT = 4'd1;
  localparam cfg_idx_t REG_VOL_DEPTH  = 4'd2;
  localparam cfg_idx_t REG_RING_STEP  = 4'd3;

endpackage

// ----- design/slms_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the sparse local mean subtract unit: request,
// response and configuration write. Depends on slms_pkg.

interface slms_req_if;
  logic                                valid;
  logic                                ready;
  slms_pkg::op_t                       op;
  logic [slms_pkg::POS_X_W-1:0]        pos_x;
  logic [slms_pkg::POS_Y_W-1:0]        pos_y;
  logic [slms_pkg::POS_Z_W-1:0]        pos_z;
  logic [slms_pkg::VOXEL_W-1:0]        voxel_in;

  modport source (output valid, op, pos_x, pos_y, pos_z, voxel_in, input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, voxel_in, output ready);
endinterface

interface slms_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [slms_pkg::RESULT_W-1:0]       result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface

interface slms_cfg_if;
  logic                                valid;
  logic                                ready;
  slms_pkg::cfg_idx_t                  index;
  slms_pkg::cfg_data_t                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/slms_div.sv -----
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Imports slms_pkg; no other dependency.
module slms_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  import slms_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_next = DEN_W'(rem_sh - {1'b0, den_q});
      q_bit    = 1'b1;
    end else begin
      rem_next = rem_sh[DEN_W-1:0];
      q_bit    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // The quotient is complete after the last of NUM_W steps.
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        quo   <= num;
        rem   <= '0;
        den_q <= den;
        cnt   <= CW'(NUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], q_bit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/sparse_local_mean_subtract_3d_unit.sv -----
`timescale 1ns / 1ps
// Top level of the sparse local mean subtract unit: voxel memory, probe
// sequencer and result register. Depends on slms_pkg, slms_if and slms_div.

// The unit keeps a MAX_WIDTH x MAX_HEIGHT x MAX_DEPTH volume of voxels in one
// internal memory. A write transaction stores one voxel; a query transaction
// returns the center voxel minus the rounded-up mean of up to 18 axial
// neighbours at one, two and three times ring_step, clamped at zero, and 0
// when the coordinate is outside the volume in use or no neighbour is inside.
// The unit takes one transaction at a time. A write is stored in the start
// step, after which the unit returns to idle and can take the next
// transaction. A query inside the volume sends the center and 18 neighbour
// probes through the single memory read port one per cycle, lets the last
// probe pass the read and accumulate stages, and takes the mean from a
// divider that produces one quotient bit per cycle over SAMPLE_BITS + 5 bits.
// A query inside the volume with no neighbour inside skips the divider. A
// query outside the volume goes from the start step straight to the finish
// step. A finished result waits in an output register, so the next
// transaction is accepted while it is still pending; a query that finishes
// while that register is still full waits until it is taken.
// Voxels must be written before they are queried; the memory is not cleared
// by reset. Configuration writes are taken at any time but must only be
// issued while the unit is idle; register indexes beyond the list are ignored.
module sparse_local_mean_subtract_3d_unit #(
  parameter int MAX_WIDTH   = slms_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = slms_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_DEPTH   = slms_pkg::DEF_MAX_DEPTH,
  parameter int SAMPLE_BITS = slms_pkg::DEF_SAMPLE_BITS
) (
  input logic      clk,
  input logic      rst,
  slms_req_if.sink   req,
  slms_rsp_if.source rsp,
  slms_cfg_if.sink   cfg
);
  import slms_pkg::*;

  localparam int VOL_ENTRIES = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
  localparam int ADDR_W      = $clog2(VOL_ENTRIES);
  // Sum of 18 samples plus the rounding term stays below 32 times a sample.
  localparam int SUM_W       = SAMPLE_BITS + 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    DIR_XM,
    DIR_XP,
    DIR_YM,
    DIR_YP,
    DIR_ZM,
    DIR_ZP
  } dir_t;

  // Configuration registers.
  logic [DIM_XY_W-1:0] vol_width;
  logic [DIM_XY_W-1:0] vol_height;
  logic [DIM_Z_W-1:0]  vol_depth;
  logic [STEP_W-1:0]   ring_step;

  // Dimensions in use after clamping to the storage size.
  logic [DIM_XY_W-1:0] w_eff;
  logic [DIM_XY_W-1:0] h_eff;
  logic [DIM_Z_W-1:0]  d_eff;

  // Held transaction.
  op_t                    op_q;
  logic [POS_X_W-1:0]     x_q;
  logic [POS_Y_W-1:0]     y_q;
  logic [POS_Z_W-1:0]     z_q;
  logic [SAMPLE_BITS-1:0] val_q;

  // Sequencer.
  state_t            state;
  dir_t              dir;
  logic [1:0]        ring;
  logic [DIST_W-1:0] nb_dist;
  logic              drain_cnt;

  // Probe pipeline: address stage, memory read stage, accumulate.
  logic [ADDR_W-1:0]      s1_addr;
  logic                   s1_hit;
  logic                   s1_center;
  logic                   s2_hit;
  logic                   s2_center;
  logic [SAMPLE_BITS-1:0] mem_q;

  // Accumulators and result.
  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       count;
  logic [SAMPLE_BITS-1:0] center;
  logic [RESULT_W-1:0]    result;
  logic                   rsp_valid;
  logic [RESULT_W-1:0]    rsp_value;

  logic [SAMPLE_BITS-1:0] mem [VOL_ENTRIES];

  logic              in_vol;
  logic [ADDR_W-1:0] item_addr;
  logic              mem_we;
  logic              center_issue;
  logic [7:0]        xs, ys, zs, ds;
  logic [7:0]        pr_x, pr_y, pr_z;
  logic              pr_ok;
  logic [ADDR_W-1:0] probe_addr;
  logic              last_probe;

  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [SUM_W-1:0] div_num;
  logic [SUM_W-1:0] div_quo;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [NB_XY_W-1:0] ax,
                                                input logic [NB_XY_W-1:0] ay,
                                                input logic [NB_Z_W-1:0]  az);
    logic [31:0] lin;
    lin = (32'(az) * 32'(MAX_HEIGHT) + 32'(ay)) * 32'(MAX_WIDTH) + 32'(ax);
    return lin[ADDR_W-1:0];
  endfunction

  // A dimension register larger than the storage acts as the storage size.
  assign w_eff = (32'(vol_width) > MAX_WIDTH) ? DIM_XY_W'(MAX_WIDTH) : vol_width;
  assign h_eff = (32'(vol_height) > MAX_HEIGHT) ? DIM_XY_W'(MAX_HEIGHT) : vol_height;
  assign d_eff = (32'(vol_depth) > MAX_DEPTH) ? DIM_Z_W'(MAX_DEPTH) : vol_depth;

  assign in_vol = ({1'b0, x_q} < w_eff) && ({1'b0, y_q} < h_eff) &&
                  ({1'b0, z_q} < d_eff);
  assign item_addr = addr_of({1'b0, x_q}, {1'b0, y_q}, {1'b0, z_q});
  assign mem_we    = (state == ST_START) && (op_q == OP_WRITE) && in_vol;
  // The center voxel goes through the pipeline ahead of the neighbours.
  assign center_issue = (state == ST_START) && (op_q == OP_QUERY) && in_vol;

  // One neighbour probe per scan cycle: step along one axis in one direction
  // and check that the neighbour stays inside the volume in use.
  assign xs = {2'b0, x_q};
  assign ys = {2'b0, y_q};
  assign zs = {3'b0, z_q};
  assign ds = {1'b0, nb_dist};

  always_comb begin
    pr_x  = xs;
    pr_y  = ys;
    pr_z  = zs;
    pr_ok = 1'b0;
    unique case (dir)
      DIR_XM: begin
        pr_ok = xs >= ds;
        pr_x  = xs - ds;
      end
      DIR_XP: begin
        pr_x  = xs + ds;
        pr_ok = pr_x < {1'b0, w_eff};
      end
      DIR_YM: begin
        pr_ok = ys >= ds;
        pr_y  = ys - ds;
      end
      DIR_YP: begin
        pr_y  = ys + ds;
        pr_ok = pr_y < {1'b0, h_eff};
      end
      DIR_ZM: begin
        pr_ok = zs >= ds;
        pr_z  = zs - ds;
      end
      DIR_ZP: begin
        pr_z  = zs + ds;
        pr_ok = pr_z < {2'b0, d_eff};
      end
      default: ;
    endcase
  end

  assign probe_addr = addr_of(pr_x[NB_XY_W-1:0], pr_y[NB_XY_W-1:0], pr_z[NB_Z_W-1:0]);
  assign last_probe = (ring == 2'd3) && (dir == DIR_ZP);

  // Rounded-up mean: divide sum + count - 1 by count.
  assign div_start = (state == ST_DIV_GO) && (count != '0);
  assign div_num   = SUM_W'(sum + SUM_W'(count) - SUM_W'(1));

  slms_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (count),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.result_value = rsp_value;
  assign cfg.ready        = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vol_width  <= RST_VOL_WIDTH;
      vol_height <= RST_VOL_HEIGHT;
      vol_depth  <= RST_VOL_DEPTH;
      ring_step  <= RST_RING_STEP;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_VOL_WIDTH:  vol_width  <= cfg.data[DIM_XY_W-1:0];
        REG_VOL_HEIGHT: vol_height <= cfg.data[DIM_XY_W-1:0];
        REG_VOL_DEPTH:  vol_depth  <= cfg.data[DIM_Z_W-1:0];
        REG_RING_STEP:  ring_step  <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Voxel memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item_addr] <= val_q;
    end
    mem_q <= mem[s1_addr];
  end

  // Probe flags: issued with the address, then carried alongside the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_hit    <= 1'b0;
      s1_center <= 1'b0;
      s2_hit    <= 1'b0;
      s2_center <= 1'b0;
    end else begin
      s1_hit    <= center_issue || ((state == ST_SCAN) && pr_ok);
      s1_center <= center_issue;
      s2_hit    <= s1_hit;
      s2_center <= s1_center;
    end
  end

  // Sequencer, probe issue, accumulation and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      dir       <= DIR_XM;
      ring      <= 2'd1;
      drain_cnt <= 1'b0;
      sum       <= '0;
      count     <= '0;
    end else begin
      // The finish step refills the response register itself.
      if (rsp.ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_q  <= req.op;
            x_q   <= req.pos_x;
            y_q   <= req.pos_y;
            z_q   <= req.pos_z;
            val_q <= req.voxel_in[SAMPLE_BITS-1:0];
            state <= ST_START;
          end
        end
        ST_START: begin
          sum     <= '0;
          count   <= '0;
          result  <= '0;
          dir     <= DIR_XM;
          ring    <= 2'd1;
          nb_dist <= {2'b0, ring_step};
          if (op_q == OP_WRITE) begin
            state <= ST_IDLE;
          end else if (!in_vol) begin
            state <= ST_FINISH;
          end else begin
            s1_addr <= item_addr;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          s1_addr <= probe_addr;
          if (dir == DIR_ZP) begin
            dir     <= DIR_XM;
            ring    <= ring + 2'd1;
            nb_dist <= nb_dist + {2'b0, ring_step};
          end else begin
            dir <= dir_t'(dir + 3'd1);
          end
          if (last_probe) begin
            drain_cnt <= 1'b0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // The drain state waits until the last probe has passed the read and accumulate stages.
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            state <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          if (count == '0) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (SUM_W'(center) > div_quo) begin
              result <= RESULT_W'(SAMPLE_BITS'(SUM_W'(center) - div_quo));
            end else begin
              result <= '0;
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_value <= result;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Accumulate the sample that left the memory read stage.
      if (s2_hit) begin
        if (s2_center) begin
          center <= mem_q;
        end else begin
          sum   <= sum + SUM_W'(mem_q);
          count <= count + CNT_W'(1);
        end
      end
    end
  end

`ifndef SYNTH
  // The unit must not take a new transaction while the mean is being divided.
  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !req.ready)
    else $error("request ready while divider busy");

  // At most 18 neighbours can ever be counted.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_NEIGHBORS))
    else $error("neighbour count above its bound");

  // A response appears only when the sequencer finishes a query.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !$past(rsp.valid)) |-> ($past(state) == ST_FINISH))
    else $error("response raised outside the finish step");

  // A write transaction goes straight back to idle and so never leads to a response.
  a_write_no_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START && op_q == OP_WRITE) |=> (state == ST_IDLE))
    else $error("write transaction did not return to idle");
`endif

endmodule

// ----- verif/slms_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the sparse local mean subtract unit: watches the request,
// response and configuration channels, predicts query answers and compares.
// Depends on slms_pkg and slms_if.

module slms_checker (
  input  logic       clk,
  input  logic       rst,
  slms_req_if        req,
  slms_rsp_if        rsp,
  slms_cfg_if        cfg,
  output int         errors,
  output int         outstanding
);
  import slms_pkg::*;

  // Private copy of the voxel memory and of the registers.
  bit [VOXEL_W-1:0] voxel_mem [DEF_MAX_DEPTH][DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
  logic [DIM_XY_W-1:0] width_reg;
  logic [DIM_XY_W-1:0] height_reg;
  logic [DIM_Z_W-1:0]  depth_reg;
  logic [STEP_W-1:0]   step_reg;

  logic [RESULT_W-1:0] results_due [$];
  logic [RESULT_W-1:0] want;
  int mismatches = 0;

  function automatic int unsigned used_dim(input int unsigned reg_val, input int unsigned limit);
    return (reg_val > limit) ? limit : reg_val;
  endfunction

  function automatic bit inside_volume(input int unsigned x, y, z);
    return x < used_dim(width_reg, DEF_MAX_WIDTH) && y < used_dim(height_reg, DEF_MAX_HEIGHT) &&
           z < used_dim(depth_reg, DEF_MAX_DEPTH);
  endfunction

  // Center minus the rounded-up mean of the axial neighbours, floored at zero.
  function automatic logic [RESULT_W-1:0] local_contrast(input int unsigned x, y, z);
    int unsigned w, h, d, reach, sum, count, center, mean;
    w = used_dim(width_reg, DEF_MAX_WIDTH);
    h = used_dim(height_reg, DEF_MAX_HEIGHT);
    d = used_dim(depth_reg, DEF_MAX_DEPTH);
    if (!inside_volume(x, y, z)) return '0;
    sum = 0;
    count = 0;
    for (int n = 1; n <= 3; n++) begin
      reach = step_reg * n;
      if (x >= reach) begin sum += voxel_mem[z][y][x - reach]; count++; end
      if (x + reach < w) begin sum += voxel_mem[z][y][x + reach]; count++; end
      if (y >= reach) begin sum += voxel_mem[z][y - reach][x]; count++; end
      if (y + reach < h) begin sum += voxel_mem[z][y + reach][x]; count++; end
      if (z >= reach) begin sum += voxel_mem[z - reach][y][x]; count++; end
      if (z + reach < d) begin sum += voxel_mem[z + reach][y][x]; count++; end
    end
    if (count == 0) return '0;
    center = voxel_mem[z][y][x];
    mean = (sum + count - 1) / count;
    return (center > mean) ? RESULT_W'(center - mean) : '0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RST_VOL_WIDTH;
      height_reg = RST_VOL_HEIGHT;
      depth_reg  = RST_VOL_DEPTH;
      step_reg   = RST_RING_STEP;
      results_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_VOL_WIDTH:  width_reg  = cfg.data[DIM_XY_W-1:0];
          REG_VOL_HEIGHT: height_reg = cfg.data[DIM_XY_W-1:0];
          REG_VOL_DEPTH:  depth_reg  = cfg.data[DIM_Z_W-1:0];
          REG_RING_STEP:  step_reg   = cfg.data[STEP_W-1:0];
          default: ;
        endcase
      end
      // A response always belongs to a query taken at an earlier edge.
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result_value with no query pending, expected none, actual %0d",
                   $time, rsp.result_value);
        end else begin
          want = results_due.pop_front();
          if (rsp.result_value !== want) begin
            mismatches++;
            $display("%0t: result_value expected %0d, actual %0d", $time, want,
                     rsp.result_value);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_WRITE) begin
          if (inside_volume(req.pos_x, req.pos_y, req.pos_z))
            voxel_mem[req.pos_z][req.pos_y][req.pos_x] = req.voxel_in;
        end else begin
          results_due.push_back(local_contrast(req.pos_x, req.pos_y, req.pos_z));
        end
      end
    end
    errors      <= mismatches;
    outstanding <= results_due.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Top of the sparse local mean subtract unit testbench: clock, reset, stimulus
// and verdict. Depends on slms_pkg, slms_if, the unit and slms_checker.

module tb;
  import slms_pkg::*;

  logic clk = 1'b0;
  logic rst;

  slms_req_if req ();
  slms_rsp_if rsp ();
  slms_cfg_if cfg ();

  int errors;
  int outstanding;

  sparse_local_mean_subtract_3d_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // The checker sees every transaction on all three channels and reports the
  // number of mismatches and the number of queries still waiting for an answer.
  slms_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Stimulus-side view of the volume in use. It only decides which voxels a
  // query will touch, so that every one of them is written beforehand.
  bit filled [DEF_MAX_DEPTH][DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
  int unsigned eff_w = DEF_MAX_WIDTH;
  int unsigned eff_h = DEF_MAX_HEIGHT;
  int unsigned eff_d = DEF_MAX_DEPTH;
  int unsigned step_now = RST_RING_STEP;

  int items_sent = 0;
  int req_idle_pct = 0;
  int rsp_stall_pct = 0;
  logic rsp_hold = 1'b0;

  // The response side stalls at random each cycle. A long hold-off, started
  // in a process of its own, forces it low regardless of the random draw.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= !rst && !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  task automatic hold_results(input int cycles);
    rsp_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rsp_hold <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    req_idle_pct = send_pct;
    rsp_stall_pct <= stall_pct;
  endtask

  // Offers one transaction, after a random gap, and returns once it has been
  // taken. Valid stays high so that back-to-back transactions have no bubble.
  task automatic send_req(input op_t op, input logic [POS_X_W-1:0] x,
                          input logic [POS_Y_W-1:0] y, input logic [POS_Z_W-1:0] z,
                          input logic [VOXEL_W-1:0] v);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.op       <= op;
    req.pos_x    <= x;
    req.pos_y    <= y;
    req.pos_z    <= z;
    req.voxel_in <= v;
    do @(posedge clk); while (!req.ready);
  endtask

  // Register writes are issued back to back; the caller drops valid after the
  // last one of a batch.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Writes all four registers plus one index past the end of the register
  // list, which the unit has to ignore. Dimensions above the storage size act
  // as the storage size.
  task automatic configure(input cfg_data_t w, h, d, s);
    write_reg(REG_VOL_WIDTH, w);
    write_reg(REG_VOL_HEIGHT, h);
    write_reg(REG_VOL_DEPTH, d);
    write_reg(REG_RING_STEP, s);
    write_reg(cfg_idx_t'($urandom_range(REG_RING_STEP + 1, 2 ** CFG_IDX_W - 1)),
              cfg_data_t'($urandom));
    cfg.valid <= 1'b0;
    eff_w = (w[DIM_XY_W-1:0] > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w[DIM_XY_W-1:0];
    eff_h = (h[DIM_XY_W-1:0] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h[DIM_XY_W-1:0];
    eff_d = (d[DIM_Z_W-1:0] > DEF_MAX_DEPTH) ? DEF_MAX_DEPTH : d[DIM_Z_W-1:0];
    step_now = s[STEP_W-1:0];
  endtask

  // Stops offering transactions until every query has been answered, then
  // leaves a few more cycles for a trailing voxel write to retire.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic bit in_volume(input int unsigned x, y, z);
    return x < eff_w && y < eff_h && z < eff_d;
  endfunction

  // Mostly random intensities, with the extremes and tiny values mixed in so
  // that both clamped and non-clamped answers show up.
  function automatic logic [VOXEL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return VOXEL_W'($urandom_range(0, 15));
      default: return VOXEL_W'($urandom);
    endcase
  endfunction

  // Coordinates lean toward the faces of the volume in use; one draw in eight
  // covers the whole field and so may land outside.
  function automatic int unsigned pick_coord(input int unsigned limit, input int unsigned top);
    if (limit == 0) return $urandom_range(0, top);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return limit - 1;
      2: return $urandom_range(0, top);
      default: return $urandom_range(0, limit - 1);
    endcase
  endfunction

  // Writes outside the volume are dropped by the unit and do not count.
  task automatic put_voxel(input int unsigned x, y, z, input logic [VOXEL_W-1:0] v);
    send_req(OP_WRITE, POS_X_W'(x), POS_Y_W'(y), POS_Z_W'(z), v);
    if (in_volume(x, y, z)) begin
      filled[z][y][x] = 1'b1;
      items_sent++;
    end
  endtask

  // Makes sure a voxel holds data before it is read; now and then it is
  // rewritten so that stored values keep changing.
  task automatic prime(input int unsigned x, y, z);
    if (!filled[z][y][x] || $urandom_range(0, 9) == 0)
      put_voxel(x, y, z, pick_value());
  endtask

  // A well-formed query: first the center and every neighbour that lies in
  // the volume get written if needed, then the query itself goes out. A query
  // outside the volume reads nothing and answers zero.
  task automatic probe(input int unsigned x, y, z);
    int unsigned reach;
    if (in_volume(x, y, z)) begin
      prime(x, y, z);
      for (int n = 1; n <= 3; n++) begin
        reach = step_now * n;
        if (x >= reach) prime(x - reach, y, z);
        if (x + reach < eff_w) prime(x + reach, y, z);
        if (y >= reach) prime(x, y - reach, z);
        if (y + reach < eff_h) prime(x, y + reach, z);
        if (z >= reach) prime(x, y, z - reach);
        if (z + reach < eff_d) prime(x, y, z + reach);
      end
    end
    send_req(OP_QUERY, POS_X_W'(x), POS_Y_W'(y), POS_Z_W'(z), VOXEL_W'($urandom));
    items_sent++;
  endtask

  task automatic random_item();
    int unsigned x, y, z;
    x = pick_coord(eff_w, 2 ** POS_X_W - 1);
    y = pick_coord(eff_h, 2 ** POS_Y_W - 1);
    z = pick_coord(eff_d, 2 ** POS_Z_W - 1);
    // One transaction in five is a lone write, the rest are full query sequences.
    if ($urandom_range(0, 4) == 0) put_voxel(x, y, z, pick_value());
    else probe(x, y, z);
  endtask

  // Runs a quarter of the items in each idling pattern: none, sender idle,
  // receiver stalling, and both.
  task automatic random_items(input int n);
    int goal;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(69, 0);
        2: set_idling(0, 69);
        default: set_idling(19, 19);
      endcase
      goal = items_sent + n / 4;
      while (items_sent < goal) random_item();
    end
  endtask

  task automatic run_phase(input cfg_data_t w, h, d, s, input int n);
    drain();
    configure(w, h, d, s);
    random_items(n);
  endtask

  initial begin
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.op       <= OP_WRITE;
    req.pos_x    <= '0;
    req.pos_y    <= '0;
    req.pos_z    <= '0;
    req.voxel_in <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= REG_VOL_WIDTH;
    cfg.data     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: the two far corners of the full volume at the largest
    // step, one with a full-scale center and one with a zero center that has
    // to clamp.
    configure(8'd64, 8'd64, 8'd32, 8'd31);
    put_voxel(0, 0, 0, '1);
    probe(0, 0, 0);
    put_voxel(63, 63, 31, '0);
    probe(63, 63, 31);
    drain();

    // The receiver holds off for a long stretch while queries keep coming, so
    // the result register fills and the unit has to stall its input.
    set_idling(0, 0);
    fork
      hold_results(600);
    join_none
    repeat (12) probe(0, 0, 0);

    // Reset values back, then a tiny volume where every neighbour is near.
    run_phase(8'd64, 8'd64, 8'd32, 8'd5, 260);
    run_phase(8'd4, 8'd4, 8'd2, 8'd1, 200);
    // A zero step: every neighbour is the center itself. The upper data bits
    // lie outside the step register and are dropped.
    run_phase(8'd8, 8'd8, 8'd8, 8'hE0, 120);
    // Zero dimensions: nothing is inside, every query answers zero.
    run_phase(8'd0, 8'd64, 8'd32, 8'd3, 30);
    run_phase(8'd64, 8'd64, 8'd0, 8'd3, 20);
    // Dimensions above the storage size act as the storage size.
    run_phase(8'hFF, 8'd100, 8'hFF, 8'd2, 260);
    // A single voxel has no neighbour at all.
    run_phase(8'd1, 8'd1, 8'd1, 8'd1, 40);
    run_phase(8'd20, 8'd33, 8'd7, 8'd3, 250);
    repeat (2)
      run_phase(cfg_data_t'($urandom_range(1, 64)), cfg_data_t'($urandom_range(1, 64)),
                cfg_data_t'($urandom_range(1, 32)), cfg_data_t'($urandom_range(1, 31)), 300);

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/slms_pkg.sv
design/slms_if.sv
design/slms_div.sv
design/sparse_local_mean_subtract_3d_unit.sv
verif/slms_checker.sv
verif/tb.sv
